// File: src/pts_pkg.sv
// shared codes and types for the priority thread scheduler
// no dependencies
package pts_pkg;

  localparam int DefMaxThreads = 16;
  localparam int DefMaxMutexes = 8;

  // request modes
  localparam logic [2:0] MODE_CREATE = 3'd0;
  localparam logic [2:0] MODE_YIELD  = 3'd1;
  localparam logic [2:0] MODE_EXIT   = 3'd2;
  localparam logic [2:0] MODE_JOIN   = 3'd3;
  localparam logic [2:0] MODE_LOCK   = 3'd4;
  localparam logic [2:0] MODE_UNLOCK = 3'd5;

  // result status codes
  localparam logic [2:0] STAT_OK        = 3'd0;
  localparam logic [2:0] STAT_NOT_FOUND = 3'd1;
  localparam logic [2:0] STAT_BLOCKED   = 3'd2;
  localparam logic [2:0] STAT_DEADLOCK  = 3'd3;
  localparam logic [2:0] STAT_FULL      = 3'd4;
  localparam logic [2:0] STAT_NOT_OWNER = 3'd5;
  localparam logic [2:0] STAT_UNLOCKED  = 3'd6;

  // thread states
  localparam logic [2:0] TS_FREE    = 3'd0;
  localparam logic [2:0] TS_READY   = 3'd1;
  localparam logic [2:0] TS_SCHED   = 3'd2;
  localparam logic [2:0] TS_BLOCKED = 3'd3;
  localparam logic [2:0] TS_DEAD    = 3'd4;

  // mutex table command
  typedef struct packed {
    logic acquire;
    logic unlock;
  } pts_mutex_cmd_t;

endpackage

// File: src/priority_thread_scheduler_core.sv
// top level of the priority thread scheduler: thread table, run order and sequencer
// depends on pts_pkg and pts_mutex
// A request is taken when start is high and busy is low, and its single result
// appears for one cycle with done high; it cannot be held off. Create when full,
// a granted lock, unlock and bad modes finish without a walk. A schedule walks
// the run order to unlink the running thread, walks it again to reinsert that
// thread by priority, and walks it a third time to search for the first ready
// thread, all three with the one shared walk index.
module priority_thread_scheduler_core import pts_pkg::*; #(
  parameter int MAX_THREADS = DefMaxThreads,
  parameter int MAX_MUTEXES = DefMaxMutexes
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] mode,
  input  logic [3:0] target_thread,
  input  logic [2:0] mutex_index,
  output logic       done,
  output logic [2:0] status,
  output logic [3:0] running_thread,
  output logic [3:0] thread_slot,
  output logic       switched
);

  localparam int TW = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
  localparam int LW = $clog2(MAX_THREADS + 1);
  localparam int MW = (MAX_MUTEXES > 1) ? $clog2(MAX_MUTEXES) : 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DISP = 3'd1;
  localparam logic [2:0] S_UNL  = 3'd2;
  localparam logic [2:0] S_INS  = 3'd3;
  localparam logic [2:0] S_PICK = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  // thread table
  logic [2:0]    tstate  [MAX_THREADS];
  logic [15:0]   prio    [MAX_THREADS];
  logic          jw_v    [MAX_THREADS];
  logic [TW-1:0] jw      [MAX_THREADS];
  logic          bm_v    [MAX_THREADS];
  logic [MW-1:0] bm      [MAX_THREADS];
  logic [TW-1:0] ro      [MAX_THREADS];
  logic [LW-1:0] len;
  logic [TW-1:0] cur;

  // sequencer
  logic [2:0]    state;
  logic [2:0]    req_mode;
  logic [7:0]    req_t;
  logic [7:0]    req_m;
  logic [LW-1:0] i;
  logic          found;
  logic          ins;
  logic [TW-1:0] carry;
  logic [TW-1:0] tgt;
  logic          reap;

  // request decode
  logic          t_ok;
  logic [TW-1:0] t_idx;
  logic          m_ok;
  logic [MW-1:0] m_idx;
  assign t_ok  = req_t < 8'(MAX_THREADS);
  assign t_idx = req_t[TW-1:0];
  assign m_ok  = req_m < 8'(MAX_MUTEXES);
  assign m_idx = req_m[MW-1:0];

  // walk position reads
  logic [LW-1:0] ip1;
  logic [TW-1:0] ro_i;
  logic [TW-1:0] ro_ip1;
  assign ip1    = i + LW'(1);
  assign ro_i   = ro[i[TW-1:0]];
  assign ro_ip1 = ro[ip1[TW-1:0]];

  // lowest free slot
  logic          free_hit;
  logic [TW-1:0] free_slot;
  always_comb begin
    free_hit  = 1'b0;
    free_slot = '0;
    for (int k = MAX_THREADS - 1; k >= 0; k--) begin
      if (tstate[k] == TS_FREE) begin
        free_hit  = 1'b1;
        free_slot = TW'(k);
      end
    end
  end

  // mutex table
  pts_mutex_cmd_t mx_cmd;
  logic           mx_locked;
  logic [TW-1:0]  mx_owner;
  always_comb begin
    mx_cmd.acquire = (state == S_DISP) && (req_mode == MODE_LOCK) && m_ok && !mx_locked;
    mx_cmd.unlock  = (state == S_DISP) && (req_mode == MODE_UNLOCK) && m_ok && mx_locked &&
                     (mx_owner == cur);
  end

  pts_mutex #(
    .MAX_THREADS(MAX_THREADS),
    .MAX_MUTEXES(MAX_MUTEXES)
  ) u_mutex (
    .clk      (clk),
    .rst      (rst),
    .cmd      (mx_cmd),
    .idx      (m_idx),
    .caller   (cur),
    .is_locked(mx_locked),
    .owner    (mx_owner)
  );

  // pick outcome for the current walk position
  logic          pick_end;
  logic          pick_hit;
  logic [TW-1:0] pick_n;
  logic          sched_ok;
  assign pick_hit = (i != len) && (tstate[ro_i] == TS_READY);
  assign pick_end = (i == len) || pick_hit;
  assign sched_ok = pick_hit || (tstate[cur] == TS_SCHED);
  assign pick_n   = pick_hit ? ro_i : cur;

  logic [7:0] cur_w;
  assign cur_w          = 8'(cur);
  assign running_thread = cur_w[3:0];
  assign busy           = (state != S_IDLE);
  assign done           = (state == S_DONE);

  // main sequencer and table updates
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      for (int k = 0; k < MAX_THREADS; k++) begin
        tstate[k] <= TS_FREE;
        prio[k]   <= '0;
        jw_v[k]   <= 1'b0;
        jw[k]     <= '0;
        bm_v[k]   <= 1'b0;
        bm[k]     <= '0;
        ro[k]     <= '0;
      end
      tstate[0] <= TS_SCHED;
      prio[0]   <= 16'd1;
      len       <= LW'(1);
      cur       <= '0;
      i         <= '0;
      found     <= 1'b0;
      ins       <= 1'b0;
      reap      <= 1'b0;
      carry     <= '0;
      tgt       <= '0;
      req_mode  <= '0;
      req_t     <= '0;
      req_m     <= '0;
      status      <= STAT_OK;
      thread_slot <= '0;
      switched    <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            req_mode <= mode;
            req_t    <= 8'(target_thread);
            req_m    <= 8'(mutex_index);
            state    <= S_DISP;
          end
        end

        // decode the request against the table
        S_DISP: begin
          status      <= STAT_NOT_FOUND;
          thread_slot <= '0;
          switched    <= 1'b0;
          i           <= '0;
          found       <= 1'b0;
          ins         <= 1'b0;
          reap        <= 1'b0;
          tgt         <= cur;
          state       <= S_DONE;
          case (req_mode)
            MODE_CREATE: begin
              if (free_hit && (len < LW'(MAX_THREADS))) begin
                tstate[free_slot] <= TS_READY;
                prio[free_slot]   <= '0;
                jw_v[free_slot]   <= 1'b0;
                bm_v[free_slot]   <= 1'b0;
                carry             <= free_slot;
                status            <= STAT_OK;
                thread_slot       <= 4'(free_slot);
                state             <= S_INS;
              end else begin
                status <= STAT_FULL;
              end
            end
            MODE_YIELD: state <= S_UNL;
            MODE_EXIT: begin
              if (tstate[cur] != TS_FREE) begin
                if (jw_v[cur] && (tstate[jw[cur]] == TS_BLOCKED)) begin
                  tstate[jw[cur]] <= TS_READY;
                end
                jw_v[cur]   <= 1'b0;
                tstate[cur] <= TS_DEAD;
                status      <= STAT_OK;
                state       <= S_PICK;
              end
            end
            MODE_JOIN: begin
              thread_slot <= req_t[3:0];
              if (t_ok && (tstate[t_idx] != TS_FREE)) begin
                if (tstate[t_idx] == TS_DEAD) begin
                  tstate[t_idx] <= TS_FREE;
                  prio[t_idx]   <= '0;
                  jw_v[t_idx]   <= 1'b0;
                  bm_v[t_idx]   <= 1'b0;
                  tgt           <= t_idx;
                  reap          <= 1'b1;
                  status        <= STAT_OK;
                end else begin
                  tstate[cur] <= TS_BLOCKED;
                  jw_v[t_idx] <= 1'b1;
                  jw[t_idx]   <= cur;
                end
                state <= S_UNL;
              end
            end
            MODE_LOCK: begin
              if (m_ok) begin
                if (!mx_locked) begin
                  status <= STAT_OK;
                end else begin
                  tstate[cur] <= TS_BLOCKED;
                  bm_v[cur]   <= 1'b1;
                  bm[cur]     <= m_idx;
                  state       <= S_UNL;
                end
              end
            end
            MODE_UNLOCK: begin
              if (m_ok) begin
                if (!mx_locked) begin
                  status <= STAT_UNLOCKED;
                end else if (mx_owner != cur) begin
                  status <= STAT_NOT_OWNER;
                end else begin
                  status <= STAT_OK;
                  for (int k = 0; k < MAX_THREADS; k++) begin
                    if ((tstate[k] == TS_BLOCKED) && bm_v[k] && (bm[k] == m_idx)) begin
                      tstate[k] <= TS_READY;
                      bm_v[k]   <= 1'b0;
                    end
                  end
                end
              end
            end
            default: status <= STAT_NOT_FOUND;
          endcase
        end

        // unlink tgt, shifting later entries down one per cycle
        S_UNL: begin
          if (i < len) begin
            if (found || (ro_i == tgt)) begin
              found <= 1'b1;
              if (ip1 < len) begin
                ro[i[TW-1:0]] <= ro_ip1;
              end
            end
            i <= ip1;
          end else begin
            if (found) begin
              len <= len - LW'(1);
            end
            i     <= '0;
            ins   <= 1'b0;
            carry <= cur;
            if (reap) begin
              state <= S_DONE;
            end else if ((tstate[cur] == TS_FREE) ||
                         ((found ? len - LW'(1) : len) >= LW'(MAX_THREADS))) begin
              state <= S_PICK;
            end else begin
              state <= S_INS;
            end
          end
        end

        // insert carry by bubbling it forward through the run order
        S_INS: begin
          if (i == len) begin
            ro[i[TW-1:0]] <= carry;
            len           <= len + LW'(1);
            i             <= '0;
            state         <= (req_mode == MODE_CREATE) ? S_DONE : S_PICK;
          end else begin
            if (ins || (req_mode == MODE_CREATE) || (prio[ro_i] > prio[cur])) begin
              ro[i[TW-1:0]] <= carry;
              carry         <= ro_i;
              ins           <= 1'b1;
            end
            i <= ip1;
          end
        end

        // search for the first ready entry and grant it
        S_PICK: begin
          if (!pick_end) begin
            i <= ip1;
          end else begin
            state <= S_DONE;
            if (req_mode == MODE_EXIT) begin
              if (pick_hit) begin
                tstate[ro_i] <= TS_SCHED;
                if (prio[ro_i] != 16'hFFFF) begin
                  prio[ro_i] <= prio[ro_i] + 16'd1;
                end
                cur      <= ro_i;
                switched <= (ro_i != cur);
              end
            end else if (!sched_ok) begin
              status <= STAT_DEADLOCK;
            end else begin
              if ((tstate[cur] == TS_SCHED) && (pick_n != cur)) begin
                tstate[cur] <= TS_READY;
              end
              tstate[pick_n] <= TS_SCHED;
              if (prio[pick_n] != 16'hFFFF) begin
                prio[pick_n] <= prio[pick_n] + 16'd1;
              end
              cur      <= pick_n;
              switched <= (pick_n != cur);
              status   <= (req_mode == MODE_YIELD) ? STAT_OK : STAT_BLOCKED;
            end
          end
        end

        S_DONE: state <= S_IDLE;

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: src/pts_mutex.sv
// mutex table: lock flag and owner per mutex
// depends on pts_pkg
module pts_mutex import pts_pkg::*; #(
  parameter int MAX_THREADS = DefMaxThreads,
  parameter int MAX_MUTEXES = DefMaxMutexes,
  localparam int TW = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1,
  localparam int MW = (MAX_MUTEXES > 1) ? $clog2(MAX_MUTEXES) : 1
) (
  input  logic           clk,
  input  logic           rst,
  input  pts_mutex_cmd_t cmd,
  input  logic [MW-1:0]  idx,
  input  logic [TW-1:0]  caller,
  output logic           is_locked,
  output logic [TW-1:0]  owner
);

  logic          locked [MAX_MUTEXES];
  logic [TW-1:0] owners [MAX_MUTEXES];

  // read port at the requested mutex
  assign is_locked = locked[idx];
  assign owner     = owners[idx];

  // lock and unlock updates
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < MAX_MUTEXES; k++) begin
        locked[k] <= 1'b0;
        owners[k] <= '0;
      end
    end else if (cmd.acquire) begin
      locked[idx] <= 1'b1;
      owners[idx] <= caller;
    end else if (cmd.unlock) begin
      locked[idx] <= 1'b0;
      owners[idx] <= '0;
    end
  end

endmodule
